/* hdl/npq_pkg.sv */
package npq_pkg;

  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SQ_W       = 2 * CHAN_W;
  localparam int unsigned DIST_W     = SQ_W + 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(16);
  localparam logic [DIST_W-1:0]  DIST_MAX     = '1;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PALETTE_COUNT   = 2'd0,
    REG_QUANTIZE_ENABLE = 2'd1
  } reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // One item as it moves down the chain, with the best match found so far.
  typedef struct packed {
    logic              valid;
    cmd_e              cmd;
    logic [IDX_W-1:0]  entry_index;
    rgb_t              pix;
    logic              frame_end;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_index;
    rgb_t              best_color;
  } stage_t;

endpackage

/* hdl/npq_in_if.sv */
interface npq_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] entry_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       frame_end_in;

  modport source (
    output valid, cmd, entry_index, red_in, green_in, blue_in, frame_end_in,
    input  ready
  );

  modport sink (
    input  valid, cmd, entry_index, red_in, green_in, blue_in, frame_end_in,
    output ready
  );
endinterface

/* hdl/npq_out_if.sv */
interface npq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [3:0] chosen_index;
  logic       frame_end_out;

  modport source (
    output valid, red_out, green_out, blue_out, chosen_index, frame_end_out,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, chosen_index, frame_end_out,
    output ready
  );
endinterface

/* hdl/nearest_palette_color_quantizer.sv */
// Nearest palette color quantizer. Load the palette with write items (cmd 0,
// entry_index, color), then stream pixels (cmd 1); each pixel yields one
// result item with the color and index of the palette entry at the smallest
// squared RGB distance, the higher index winning a tie. Palette writes yield
// no result. Register palette_count (index 0) sets how many entries from
// entry zero take part, though entry zero always does; quantize_enable
// (index 1) at zero passes pixels through with index zero. The block is a
// chain of PALETTE_DEPTH cells, each holding one palette entry and its own
// distance unit. Every item, write or pixel, moves one cell per cycle while
// no result waits unclaimed at the end, so the chain then takes one item
// every cycle; a result passes through every cell's register in order and is
// offered from the last. Writes travel in the same stream, so a pixel always
// sees exactly the writes accepted before it. The last cell's register is the
// output stage; when a result waits there unclaimed the whole chain holds.
module nearest_palette_color_quantizer #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  npq_in_if.sink                           in_ch,
  npq_out_if.source                        out_ch,
  input  logic                             cfg_we_i,
  input  logic [npq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [npq_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  logic [npq_pkg::COUNT_W-1:0] count_q;
  logic                        enable_q;
  logic                        adv;

  npq_pkg::stage_t chain [PALETTE_DEPTH+1];
  npq_pkg::stage_t tail;

  // Configuration registers; unknown indexes drop the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= npq_pkg::COUNT_RESET;
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (npq_pkg::reg_e'(cfg_index_i))
        npq_pkg::REG_PALETTE_COUNT:   count_q  <= cfg_wdata_i;
        npq_pkg::REG_QUANTIZE_ENABLE: enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Seed the chain: the bypass answer is the pixel itself at index zero.
  always_comb begin
    chain[0].valid       = in_ch.valid;
    chain[0].cmd         = npq_pkg::cmd_e'(in_ch.cmd);
    chain[0].entry_index = in_ch.entry_index;
    chain[0].pix.red     = in_ch.red_in;
    chain[0].pix.green   = in_ch.green_in;
    chain[0].pix.blue    = in_ch.blue_in;
    chain[0].frame_end   = in_ch.frame_end_in;
    chain[0].best_dist   = npq_pkg::DIST_MAX;
    chain[0].best_index  = '0;
    chain[0].best_color.red   = in_ch.red_in;
    chain[0].best_color.green = in_ch.green_in;
    chain[0].best_color.blue  = in_ch.blue_in;
  end

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    npq_cell #(
      .CELL_ID (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .count_i  (count_q),
      .enable_i (enable_q),
      .stage_i  (chain[i]),
      .stage_o  (chain[i+1])
    );
  end

  assign tail = chain[PALETTE_DEPTH];

  // Write items drop off the end; pixels wait for the sink.
  assign out_ch.valid         = tail.valid && (tail.cmd == npq_pkg::CMD_PIXEL);
  assign out_ch.red_out       = tail.best_color.red;
  assign out_ch.green_out     = tail.best_color.green;
  assign out_ch.blue_out      = tail.best_color.blue;
  assign out_ch.chosen_index  = tail.best_index;
  assign out_ch.frame_end_out = tail.frame_end;

  // Advance the whole chain unless a result is stuck at the end.
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

endmodule

/* hdl/npq_cell.sv */
module npq_cell #(
  parameter int unsigned CELL_ID = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [npq_pkg::COUNT_W-1:0]   count_i,
  input  logic                          enable_i,
  input  npq_pkg::stage_t               stage_i,
  output npq_pkg::stage_t               stage_o
);

  npq_pkg::rgb_t   entry_q;
  npq_pkg::stage_t stage_q, stage_d;

  logic [npq_pkg::CHAN_W-1:0] diff_r, diff_g, diff_b;
  logic [npq_pkg::SQ_W-1:0]   sq_r, sq_g, sq_b;
  logic [npq_pkg::DIST_W-1:0] sum_dist;
  logic                       in_use;
  logic                       take;
  logic                       wr_hit;

  // Absolute channel differences, then squares and their sum.
  always_comb begin
    diff_r = (stage_i.pix.red >= entry_q.red) ? stage_i.pix.red - entry_q.red
                                              : entry_q.red - stage_i.pix.red;
    diff_g = (stage_i.pix.green >= entry_q.green) ? stage_i.pix.green - entry_q.green
                                                  : entry_q.green - stage_i.pix.green;
    diff_b = (stage_i.pix.blue >= entry_q.blue) ? stage_i.pix.blue - entry_q.blue
                                                : entry_q.blue - stage_i.pix.blue;
    sq_r = npq_pkg::SQ_W'(diff_r) * npq_pkg::SQ_W'(diff_r);
    sq_g = npq_pkg::SQ_W'(diff_g) * npq_pkg::SQ_W'(diff_g);
    sq_b = npq_pkg::SQ_W'(diff_b) * npq_pkg::SQ_W'(diff_b);
    sum_dist = npq_pkg::DIST_W'(sq_r) + npq_pkg::DIST_W'(sq_g) + npq_pkg::DIST_W'(sq_b);
  end

  assign in_use = 32'(CELL_ID) < 32'(count_i);

  // While quantizing, entry zero always seeds the result; later ties win.
  assign take = stage_i.valid && (stage_i.cmd == npq_pkg::CMD_PIXEL) && enable_i &&
                ((CELL_ID == 0) || (in_use && (sum_dist <= stage_i.best_dist)));

  assign wr_hit = stage_i.valid && (stage_i.cmd == npq_pkg::CMD_WRITE) &&
                  (32'(stage_i.entry_index) == 32'(CELL_ID));

  always_comb begin
    stage_d = stage_i;
    if (take) begin
      stage_d.best_dist  = sum_dist;
      stage_d.best_index = npq_pkg::IDX_W'(CELL_ID);
      stage_d.best_color = entry_q;
    end
  end

  // Only the valid bit needs a reset; the payload follows it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  // Capture the entry as its write item passes by.
  always_ff @(posedge clk_i) begin
    if (adv_i && wr_hit) begin
      entry_q <= stage_i.pix;
    end
  end

  assign stage_o = stage_q;

  a_dist_never_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && stage_i.valid |=> stage_q.best_dist <= $past(stage_i.best_dist))
    else $error("best distance grew in a cell");

  a_entry_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && wr_hit |=> entry_q == $past(stage_i.pix))
    else $error("palette entry missed its write item");

  a_payload_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && stage_i.valid |=>
      stage_q.pix == $past(stage_i.pix) && stage_q.frame_end == $past(stage_i.frame_end))
    else $error("item payload altered in a cell");

endmodule
